// ===== rtl/kht_pkg.sv =====
// ----------------------------------------------------------------------------
// kht_pkg
// Shared constants, types and helpers of the k-mer hash table insert block.
// ----------------------------------------------------------------------------
package kht_pkg;

    // table geometry: hashed area followed by an overflow area
    localparam int HASH_BITS  = 16;
    localparam int TABLE_SIZE = (1 << HASH_BITS) + (1 << (HASH_BITS - 4));
    localparam int SLOT_W     = HASH_BITS + 1;
    localparam int FIELD_W    = 17;
    localparam int CODE_W     = 64;
    localparam int HASH_W     = 32;
    localparam int CHAR_W     = 8;

    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [FIELD_W-1:0] field_t;
    typedef logic [CODE_W-1:0]  code_t;
    typedef logic [HASH_W-1:0]  hash_t;

    localparam slot_t TABLE_END  = slot_t'(TABLE_SIZE);
    localparam slot_t TABLE_LAST = slot_t'(TABLE_SIZE - 1);
    localparam hash_t HASH_SEED  = 32'd5381;

    typedef enum logic [2:0] {
        ENG_CLEAR,
        ENG_IDLE,
        ENG_HASH,
        ENG_PROBE,
        ENG_RESULT
    } eng_state_t;

    typedef struct packed {
        logic  start;
        code_t code;
    } hash_req_t;

    typedef struct packed {
        logic  done;
        hash_t value;
    } hash_rsp_t;

    typedef struct packed {
        logic  start;
        code_t code;
    } ins_req_t;

    typedef struct packed {
        code_t  kmer_code;
        field_t slot;
        field_t probe_count;
        field_t worst_probe;
        logic   table_full;
    } result_t;

    typedef struct packed {
        logic    ready;
        logic    valid;
        result_t item;
    } ins_rsp_t;

    // low result-field bits of a slot number, zero-extended when narrower
    function automatic field_t to_field(input slot_t x);
        logic [SLOT_W+FIELD_W-1:0] w;
        w = {{FIELD_W{1'b0}}, x};
        return w[FIELD_W-1:0];
    endfunction

endpackage

// ===== rtl/kht_char_if.sv =====
// ----------------------------------------------------------------------------
// kht_char_if
// Character channel: one nucleotide character per item, with end-of-k-mer flag.
// ----------------------------------------------------------------------------
interface kht_char_if;
    logic                       valid;
    logic                       ready;
    logic [kht_pkg::CHAR_W-1:0] base_char;
    logic                       last_char;

    modport source (output valid, output base_char, output last_char, input ready);
    modport sink   (input valid, input base_char, input last_char, output ready);
endinterface

// ===== rtl/kht_result_if.sv =====
// ----------------------------------------------------------------------------
// kht_result_if
// Result channel: one item per inserted (or dropped) k-mer.
// ----------------------------------------------------------------------------
interface kht_result_if;
    logic                 valid;
    logic                 ready;
    kht_pkg::code_t       kmer_code;
    kht_pkg::field_t      slot;
    kht_pkg::field_t      probe_count;
    kht_pkg::field_t      worst_probe;
    logic                 table_full;

    modport source (output valid, output kmer_code, output slot, output probe_count,
                    output worst_probe, output table_full, input ready);
    modport sink   (input valid, input kmer_code, input slot, input probe_count,
                    input worst_probe, input table_full, output ready);
endinterface

// ===== rtl/kht_hash_unit.sv =====
// ----------------------------------------------------------------------------
// kht_hash_unit
// Serial DJB hash over the 8 bytes of a packed code, low byte first, one
// byte per cycle; done pulses for one cycle with the 32-bit hash.
// ----------------------------------------------------------------------------
module kht_hash_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  kht_pkg::hash_req_t req,
    output kht_pkg::hash_rsp_t rsp
);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [2:0]     cnt_reg, cnt_next;
    kht_pkg::hash_t hash_reg, hash_next;
    kht_pkg::code_t code_reg, code_next;

    // one hash step per cycle: h * 33 + byte
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        hash_next = hash_reg;
        code_next = code_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 3'd0;
            hash_next = kht_pkg::HASH_SEED;
            code_next = req.code;
        end
        else if (busy_reg)
        begin
            hash_next = {hash_reg[kht_pkg::HASH_W-6:0], 5'b00000} + hash_reg
                        + {24'd0, code_reg[7:0]};
            code_next = {8'd0, code_reg[kht_pkg::CODE_W-1:8]};
            cnt_next  = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        hash_reg <= hash_next;
        code_reg <= code_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = hash_reg;

endmodule

// ===== rtl/kht_probe_engine.sv =====
// ----------------------------------------------------------------------------
// kht_probe_engine
// Key and link memories with the insert sequencer: clearing pass after
// reset, hash, linear probe one slot per cycle, write-back and result hold.
// ----------------------------------------------------------------------------
module kht_probe_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  kht_pkg::ins_req_t req,
    input  logic              take,
    output kht_pkg::ins_rsp_t rsp
);

    kht_pkg::eng_state_t state_reg, state_next;
    kht_pkg::slot_t      clr_addr_reg, clr_addr_next;
    kht_pkg::slot_t      chk_pos_reg, chk_pos_next;
    kht_pkg::slot_t      skipped_reg, skipped_next;
    kht_pkg::slot_t      prev_slot_reg, prev_slot_next;
    kht_pkg::slot_t      worst_reg, worst_next;
    kht_pkg::code_t      code_reg, code_next;
    kht_pkg::result_t    res_reg, res_next;

    kht_pkg::hash_req_t  hash_req;
    kht_pkg::hash_rsp_t  hash_rsp;

    // key and link memories, read data registered
    kht_pkg::code_t      key_mem [kht_pkg::TABLE_SIZE];
    kht_pkg::field_t     link_mem [kht_pkg::TABLE_SIZE];
    kht_pkg::code_t      key_rd_reg;

    logic                rd_en;
    kht_pkg::slot_t      rd_addr;
    logic                key_we;
    kht_pkg::slot_t      key_waddr;
    kht_pkg::code_t      key_wdata;
    logic                link_we;
    kht_pkg::slot_t      link_waddr;
    kht_pkg::field_t     link_wdata;

    kht_pkg::slot_t      start_pos;
    kht_pkg::slot_t      pos_inc;
    kht_pkg::slot_t      skipped_inc;
    kht_pkg::slot_t      worst_new;

    kht_hash_unit u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hash_req),
        .rsp   (hash_rsp)
    );

    assign start_pos   = kht_pkg::slot_t'(hash_rsp.value[kht_pkg::HASH_BITS-1:0]);
    assign pos_inc     = chk_pos_reg + kht_pkg::slot_t'(1);
    assign skipped_inc = skipped_reg + kht_pkg::slot_t'(1);
    assign worst_new   = (skipped_reg > worst_reg) ? skipped_reg : worst_reg;

    assign hash_req.start = req.start && (state_reg == kht_pkg::ENG_IDLE);
    assign hash_req.code  = req.code;

    // sequencer: next state, memory controls, result capture
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        chk_pos_next   = chk_pos_reg;
        skipped_next   = skipped_reg;
        prev_slot_next = prev_slot_reg;
        worst_next     = worst_reg;
        code_next      = code_reg;
        res_next       = res_reg;
        rd_en          = 1'b0;
        rd_addr        = chk_pos_reg;
        key_we         = 1'b0;
        key_waddr      = chk_pos_reg;
        key_wdata      = code_reg;
        link_we        = 1'b0;
        link_waddr     = prev_slot_reg;
        link_wdata     = kht_pkg::to_field(chk_pos_reg);
        rsp.ready      = 1'b0;
        rsp.valid      = 1'b0;
        rsp.item       = res_reg;
        case (state_reg)
            kht_pkg::ENG_CLEAR:
            begin
                key_we        = 1'b1;
                key_waddr     = clr_addr_reg;
                key_wdata     = '0;
                link_we       = 1'b1;
                link_waddr    = clr_addr_reg;
                link_wdata    = '0;
                clr_addr_next = clr_addr_reg + kht_pkg::slot_t'(1);
                if (clr_addr_reg == kht_pkg::TABLE_LAST)
                begin
                    state_next = kht_pkg::ENG_IDLE;
                end
            end
            kht_pkg::ENG_IDLE:
            begin
                rsp.ready = 1'b1;
                if (req.start)
                begin
                    code_next  = req.code;
                    state_next = kht_pkg::ENG_HASH;
                end
            end
            kht_pkg::ENG_HASH:
            begin
                if (hash_rsp.done)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = start_pos;
                    chk_pos_next = start_pos;
                    skipped_next = '0;
                    state_next   = kht_pkg::ENG_PROBE;
                end
            end
            kht_pkg::ENG_PROBE:
            begin
                // read data belongs to chk_pos; the next slot is read ahead
                if (key_rd_reg == '0)
                begin
                    key_we               = 1'b1;
                    link_we              = 1'b1;
                    prev_slot_next       = chk_pos_reg;
                    worst_next           = worst_new;
                    res_next.kmer_code   = code_reg;
                    res_next.slot        = kht_pkg::to_field(chk_pos_reg);
                    res_next.probe_count = kht_pkg::to_field(skipped_reg);
                    res_next.worst_probe = kht_pkg::to_field(worst_new);
                    res_next.table_full  = 1'b0;
                    state_next           = kht_pkg::ENG_RESULT;
                end
                else if (pos_inc == kht_pkg::TABLE_END)
                begin
                    // ran off the overflow area: drop the insert
                    res_next.kmer_code   = code_reg;
                    res_next.slot        = '0;
                    res_next.probe_count = kht_pkg::to_field(skipped_inc);
                    res_next.worst_probe = kht_pkg::to_field(worst_reg);
                    res_next.table_full  = 1'b1;
                    state_next           = kht_pkg::ENG_RESULT;
                end
                else
                begin
                    rd_en        = 1'b1;
                    rd_addr      = pos_inc;
                    chk_pos_next = pos_inc;
                    skipped_next = skipped_inc;
                end
            end
            kht_pkg::ENG_RESULT:
            begin
                rsp.valid = 1'b1;
                if (take)
                begin
                    state_next = kht_pkg::ENG_IDLE;
                end
            end
            default:
            begin
                state_next = kht_pkg::ENG_CLEAR;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kht_pkg::ENG_CLEAR;
            clr_addr_reg  <= '0;
            prev_slot_reg <= '0;
            worst_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            prev_slot_reg <= prev_slot_next;
            worst_reg     <= worst_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        chk_pos_reg <= chk_pos_next;
        skipped_reg <= skipped_next;
        code_reg    <= code_next;
        res_reg     <= res_next;
    end

    // memories: the write of an insert lands before the next item's first
    // read, since the serial hash lies between them, so no forwarding is needed
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_waddr] <= key_wdata;
        end
        if (rd_en)
        begin
            key_rd_reg <= key_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
    end

    // no new item while the clearing pass runs
    a_no_ready_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kht_pkg::ENG_CLEAR) |-> !rsp.ready)
        else $error("engine ready during clearing pass");

    // a held result stays until taken
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !take) |=> (rsp.valid && $stable(rsp.item)))
        else $error("result changed before it was taken");

    // a dropped insert reports slot zero
    a_full_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.item.table_full) |-> (rsp.item.slot == '0))
        else $error("dropped insert with nonzero slot");

    // the hash unit finishes only while the sequencer waits for it
    a_hash_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        hash_rsp.done |-> (state_reg == kht_pkg::ENG_HASH))
        else $error("hash done outside hash state");

    // probing stays inside the table
    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kht_pkg::ENG_PROBE) |-> (chk_pos_reg < kht_pkg::TABLE_END))
        else $error("probe position beyond table end");

endmodule

// ===== rtl/kmer_hash_table_insert.sv =====
// ----------------------------------------------------------------------------
// kmer_hash_table_insert
// Packs k-mer characters into a 64-bit code and inserts it into a linearly
// probed hash table, reporting slot, probe count and worst probe per k-mer.
// Flow: a last character's result passes through the 8 serial hash steps, the start
//   slot read, one key-memory read per probed slot, then the engine result register
//   and the output register.
// Throughput: one k-mer in flight; a plain character every cycle while the engine is
//   idle, and a last character blocks the input until its result moves to the
//   output register.
// Reset: a clearing pass over all TABLE_SIZE (69632) slots zeroes the key and link
//   memories; no character is accepted until it ends.
// ----------------------------------------------------------------------------
module kmer_hash_table_insert (
    input  logic         clk,
    input  logic         rst_n,
    kht_char_if.sink     chars,
    kht_result_if.source results
);

    kht_pkg::code_t    acc_reg, acc_next;
    kht_pkg::code_t    acc_shift;
    logic              accept;

    kht_pkg::ins_req_t eng_req;
    kht_pkg::ins_rsp_t eng_rsp;
    logic              take;

    logic              out_valid_reg, out_valid_next;
    kht_pkg::result_t  out_item_reg;

    kht_probe_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (eng_req),
        .take  (take),
        .rsp   (eng_rsp)
    );

    // character intake and 2-bit packing
    assign chars.ready = eng_rsp.ready;
    assign accept      = chars.valid && chars.ready;
    assign acc_shift   = {acc_reg[kht_pkg::CODE_W-3:0], chars.base_char[2:1]};

    always_comb
    begin
        acc_next = acc_reg;
        if (accept)
        begin
            acc_next = chars.last_char ? '0 : acc_shift;
        end
    end

    assign eng_req.start = accept && chars.last_char;
    assign eng_req.code  = acc_shift;

    // output register decouples the engine from the result sink
    assign take = eng_rsp.valid && (!out_valid_reg || results.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_item_reg <= eng_rsp.item;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.kmer_code   = out_item_reg.kmer_code;
    assign results.slot        = out_item_reg.slot;
    assign results.probe_count = out_item_reg.probe_count;
    assign results.worst_probe = out_item_reg.worst_probe;
    assign results.table_full  = out_item_reg.table_full;

endmodule
